// File: hdl/assert_macros.svh
// assertion macros for the checker in bps_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bps assertion failed");

// next-cycle implication, disabled during reset
`define BPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bps assertion failed");

`endif

// File: hdl/bps_pkg.sv
// beep pattern sequencer package: transaction payload types and constants
// no dependencies
package bps_pkg;

   localparam logic [14:0] TIMEOUT_SCALE = 15'd100;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  burst_count;
      logic [14:0] on_ticks;
      logic [14:0] gap_ticks;
      logic [14:0] rest_ticks;
      logic [7:0]  timeout_hundreds;
   } req_type;

   typedef struct packed {
      logic sounding;
   } rsp_type;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_SET  = 1'b1
   } cmd_type;

endpackage

// File: hdl/bps_stream_if.sv
// valid/ready stream interface carrying one payload per transaction
// payload type is a parameter, normally a struct from bps_pkg
interface bps_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/bps_in_reg.sv
// input register stage for the beep pattern sequencer
// depends on bps_pkg and bps_stream_if
module bps_in_reg (
   input  logic         clock,
   input  logic         reset,
   bps_stream_if.sink   req,
   bps_stream_if.source stage
);
   import bps_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type payload_ff;
   logic    load;

   // refill whenever empty or the core takes the held transaction
   assign req.ready = !valid_ff || stage.ready;
   assign load      = req.valid && req.ready;
   assign valid_in  = load || (valid_ff && !stage.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= req.payload;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.payload = payload_ff;
endmodule

// File: hdl/bps_core.sv
// pattern state, per-transaction next-state logic and result register
// depends on bps_pkg and bps_stream_if
module bps_core (
   input  logic         clock,
   input  logic         reset,
   bps_stream_if.sink   stage,
   bps_stream_if.source rsp
);
   import bps_pkg::*;

   logic [7:0]  group_size_ff, group_size_in;
   logic [14:0] tone_len_ff, tone_len_in;
   logic [14:0] gap_len_ff, gap_len_in;
   logic [14:0] rest_len_ff, rest_len_in;
   logic [14:0] stop_limit_ff, stop_limit_in;
   logic        restart_pending_ff, restart_pending_in;
   logic [7:0]  beep_index_ff, beep_index_in;
   logic [15:0] phase_ticks_ff, phase_ticks_in;
   logic [15:0] elapsed_ticks_ff, elapsed_ticks_in;
   logic        drive_level_ff, drive_level_in;
   logic        rsp_valid_ff, rsp_valid_in;

   req_type     item;
   logic        advance;
   logic        differs;
   logic [14:0] limit_value;
   logic [15:0] gap_end;
   logic [15:0] rest_end;
   logic [15:0] tone_end;

   assign item        = stage.payload;
   assign stage.ready = !rsp_valid_ff || rsp.ready;
   assign advance     = stage.valid && stage.ready;

   assign differs = (item.burst_count != group_size_ff) || (item.on_ticks != tone_len_ff) ||
                    (item.gap_ticks != gap_len_ff) || (item.rest_ticks != rest_len_ff);
   // at most 255 * 100, always fits in 15 bits
   assign limit_value = {7'd0, item.timeout_hundreds} * TIMEOUT_SCALE;
   assign tone_end    = {1'b0, tone_len_ff};
   assign gap_end     = {1'b0, tone_len_ff} + {1'b0, gap_len_ff};
   assign rest_end    = {1'b0, tone_len_ff} + {1'b0, rest_len_ff};

   always_comb begin
      group_size_in      = group_size_ff;
      tone_len_in        = tone_len_ff;
      gap_len_in         = gap_len_ff;
      rest_len_in        = rest_len_ff;
      stop_limit_in      = stop_limit_ff;
      restart_pending_in = restart_pending_ff;
      beep_index_in      = beep_index_ff;
      phase_ticks_in     = phase_ticks_ff;
      elapsed_ticks_in   = elapsed_ticks_ff;
      drive_level_in     = drive_level_ff;

      unique case (cmd_type'(item.cmd))
         CMD_SET: begin
            // timeout-only changes are dropped
            if (differs) begin
               group_size_in      = item.burst_count;
               tone_len_in        = item.on_ticks;
               gap_len_in         = item.gap_ticks;
               rest_len_in        = item.rest_ticks;
               stop_limit_in      = limit_value;
               restart_pending_in = 1'b1;
            end
         end
         CMD_TICK: begin
            priority if (restart_pending_ff) begin
               drive_level_in     = 1'b0;
               beep_index_in      = 8'd1;
               phase_ticks_in     = '0;
               elapsed_ticks_in   = '0;
               restart_pending_in = 1'b0;
            end else if (group_size_ff != 8'd0) begin
               priority if (phase_ticks_ff < tone_end) begin
                  drive_level_in = 1'b1;
                  phase_ticks_in = phase_ticks_ff + 16'd1;
               end else if (beep_index_ff < group_size_ff) begin
                  if (phase_ticks_ff < gap_end) begin
                     drive_level_in = 1'b0;
                     phase_ticks_in = phase_ticks_ff + 16'd1;
                  end else begin
                     // end of gap: level held on the wrap tick
                     phase_ticks_in = '0;
                     beep_index_in  = beep_index_ff + 8'd1;
                  end
               end else if (phase_ticks_ff < rest_end) begin
                  drive_level_in = 1'b0;
                  phase_ticks_in = phase_ticks_ff + 16'd1;
               end else begin
                  phase_ticks_in = '0;
                  beep_index_in  = 8'd1;
               end

               if (stop_limit_ff != 15'd0) begin
                  elapsed_ticks_in = elapsed_ticks_ff + 16'd1;
                  // timeout: wipe the pattern and arm a restart
                  if (elapsed_ticks_ff == {1'b0, stop_limit_ff}) begin
                     group_size_in      = '0;
                     tone_len_in        = '0;
                     gap_len_in         = '0;
                     rest_len_in        = '0;
                     stop_limit_in      = '0;
                     restart_pending_in = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff      <= '0;
         tone_len_ff        <= '0;
         gap_len_ff         <= '0;
         rest_len_ff        <= '0;
         stop_limit_ff      <= '0;
         restart_pending_ff <= 1'b0;
         beep_index_ff      <= '0;
         phase_ticks_ff     <= '0;
         elapsed_ticks_ff   <= '0;
         drive_level_ff     <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            group_size_ff      <= group_size_in;
            tone_len_ff        <= tone_len_in;
            gap_len_ff         <= gap_len_in;
            rest_len_ff        <= rest_len_in;
            stop_limit_ff      <= stop_limit_in;
            restart_pending_ff <= restart_pending_in;
            beep_index_ff      <= beep_index_in;
            phase_ticks_ff     <= phase_ticks_in;
            elapsed_ticks_ff   <= elapsed_ticks_in;
            drive_level_ff     <= drive_level_in;
         end
      end
   end

   // drive level only moves on advance, so it doubles as the result register
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.payload.sounding = drive_level_ff;
endmodule

// File: hdl/beep_pattern_sequencer_top.sv
// beep pattern sequencer: each req transaction passes the input register, then the
// pattern state and result register, before rsp valid rises.
// throughput is one transaction per cycle while rsp is ready.
// synchronous active-high reset clears all pattern state, beeper off, no clearing pass.
// depends on bps_pkg, bps_stream_if, bps_in_reg and bps_core
module beep_pattern_sequencer_top (
   input  logic         clock,
   input  logic         reset,
   bps_stream_if.sink   req,
   bps_stream_if.source rsp
);
   import bps_pkg::*;

   bps_stream_if #(.payload_type(req_type)) stage_if ();

   bps_in_reg u_in_reg (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .stage (stage_if)
   );

   bps_core u_core (
      .clock (clock),
      .reset (reset),
      .stage (stage_if),
      .rsp   (rsp)
   );
endmodule

// File: hdl/bps_checker.sv
// port-level checker for the beep pattern sequencer, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module bps_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_sounding
);
   logic [2:0] outstanding_ff;
   logic [2:0] outstanding_in;
   logic       req_take;
   logic       rsp_take;
   logic       rsp_wait;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 3'd1;
      end else if (rsp_take && !req_take) begin
         outstanding_in = outstanding_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `BPS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_sounding))
   `BPS_ASSERT_IMP(a_no_invented, clock, reset, rsp_valid, outstanding_ff != 3'd0)
   `BPS_ASSERT_IMP(a_depth, clock, reset, 1'b1, outstanding_ff <= 3'd2)
   `BPS_ASSERT_IMP(a_ready_free, clock, reset, outstanding_ff < 3'd2, req_ready)
endmodule

bind beep_pattern_sequencer_top bps_checker u_bps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_sounding (rsp.payload.sounding)
);

// File: dv/beep_pattern_sequencer_top_tb.sv
// testbench for beep_pattern_sequencer_top: directed rows, then random pattern/tick runs
// scoreboarded against an in-bench beeper model; depends on bps_pkg and bps_stream_if
module beep_pattern_sequencer_top_tb;
   import bps_pkg::*;

   localparam int RANDOM_ITEMS   = 426;
   localparam int STALL_LIMIT    = 5000;
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int DIR_ROWS       = 24;

   // how a directed row is checked
   localparam logic [1:0] WANT_OFF  = 2'd0;
   localparam logic [1:0] WANT_ON   = 2'd1;
   localparam logic [1:0] WANT_PRED = 2'd2;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  burst;
      logic [14:0] on_t;
      logic [14:0] gap_t;
      logic [14:0] rest_t;
      logic [7:0]  tmo;
      logic [1:0]  want;
   } dir_row_type;

   logic clock;
   logic reset;

   bps_stream_if #(.payload_type(req_type)) req_if ();
   bps_stream_if #(.payload_type(rsp_type)) rsp_if ();

   beep_pattern_sequencer_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // beeper model state
   logic [7:0]  mdl_group;
   logic [14:0] mdl_tone;
   logic [14:0] mdl_gap;
   logic [14:0] mdl_rest;
   logic [14:0] mdl_limit;
   logic        mdl_restart;
   logic [7:0]  mdl_index;
   logic [15:0] mdl_phase;
   logic [15:0] mdl_elapsed;
   logic        mdl_level;

   req_type     stim_items[$];
   logic [1:0]  stim_want[$];
   logic        levels_due[$];
   dir_row_type dir_rows [DIR_ROWS];

   int          send_idle_pct;
   int          rsp_stall_pct;
   bit          hold_off_req;
   int          req_taken;
   int          rsp_taken;
   int          idle_cycles;
   int          mismatches;
   int          n_sets;
   int          n_ticks;
   int          n_on;
   int          n_timeouts;
   int          n_holds;

   function automatic void load_pattern(logic [7:0] q, logic [14:0] d, logic [14:0] p,
                                        logic [14:0] r, logic [7:0] t);
      if (q != mdl_group || d != mdl_tone || p != mdl_gap || r != mdl_rest) begin
         mdl_group   = q;
         mdl_tone    = d;
         mdl_gap     = p;
         mdl_rest    = r;
         mdl_limit   = 15'(32'(t) * 32'(TIMEOUT_SCALE));
         mdl_restart = 1'b1;
      end
   endfunction

   function automatic void tone_tick();
      logic hit;
      if (mdl_restart) begin
         mdl_level   = 1'b0;
         mdl_index   = 8'd1;
         mdl_phase   = 16'd0;
         mdl_elapsed = 16'd0;
         mdl_restart = 1'b0;
         return;
      end
      if (mdl_group == 8'd0)
         return;
      if (17'(mdl_phase) < 17'(mdl_tone)) begin
         mdl_level = 1'b1;
         mdl_phase = mdl_phase + 16'd1;
      end
      else if (mdl_index < mdl_group) begin
         if (17'(mdl_phase) < 17'(mdl_tone) + 17'(mdl_gap)) begin
            mdl_level = 1'b0;
            mdl_phase = mdl_phase + 16'd1;
         end
         else begin
            // end of a gap: level held
            mdl_phase = 16'd0;
            mdl_index = mdl_index + 8'd1;
         end
      end
      else if (17'(mdl_phase) < 17'(mdl_tone) + 17'(mdl_rest)) begin
         mdl_level = 1'b0;
         mdl_phase = mdl_phase + 16'd1;
      end
      else begin
         mdl_phase = 16'd0;
         mdl_index = 8'd1;
      end
      if (mdl_limit != 15'd0) begin
         hit = (mdl_elapsed == 16'(mdl_limit));
         mdl_elapsed = mdl_elapsed + 16'd1;
         if (hit) begin
            n_timeouts++;
            load_pattern(8'd0, 15'd0, 15'd0, 15'd0, 8'd0);
         end
      end
   endfunction

   function automatic logic beeper_step(req_type t);
      if (t.cmd == CMD_SET) begin
         n_sets++;
         load_pattern(t.burst_count, t.on_ticks, t.gap_ticks, t.rest_ticks,
                      t.timeout_hundreds);
      end
      else begin
         n_ticks++;
         tone_tick();
      end
      return mdl_level;
   endfunction

   function automatic req_type pattern_cmd(logic [7:0] q, logic [14:0] d, logic [14:0] p,
                                           logic [14:0] r, logic [7:0] t);
      req_type c;
      c.cmd              = CMD_SET;
      c.burst_count      = q;
      c.on_ticks         = d;
      c.gap_ticks        = p;
      c.rest_ticks       = r;
      c.timeout_hundreds = t;
      return c;
   endfunction

   // tick with random junk in the ignored fields
   function automatic req_type noisy_tick();
      req_type c;
      c = pattern_cmd(8'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                      8'($urandom));
      c.cmd = CMD_TICK;
      return c;
   endfunction

   task automatic build_stimulus();
      req_type c;
      req_type last_set;
      int      pick;
      int      run;
      for (int i = 0; i < DIR_ROWS; i++) begin
         c = pattern_cmd(dir_rows[i].burst, dir_rows[i].on_t, dir_rows[i].gap_t,
                         dir_rows[i].rest_t, dir_rows[i].tmo);
         c.cmd = dir_rows[i].cmd;
         stim_items.push_back(c);
         stim_want.push_back(dir_rows[i].want);
      end
      // first random run is long enough to reach a one-hundred tick timeout
      last_set = pattern_cmd(8'($urandom_range(1, 3)), 15'($urandom_range(1, 4)),
                             15'($urandom_range(0, 3)), 15'($urandom_range(0, 3)), 8'd1);
      run = 115;
      while (stim_items.size() < DIR_ROWS + RANDOM_ITEMS) begin
         stim_items.push_back(last_set);
         stim_want.push_back(WANT_PRED);
         // keep the total close to the planned item count
         if (run > DIR_ROWS + RANDOM_ITEMS - stim_items.size())
            run = DIR_ROWS + RANDOM_ITEMS - stim_items.size();
         repeat (run) begin
            stim_items.push_back(noisy_tick());
            stim_want.push_back(WANT_PRED);
         end
         pick = $urandom_range(0, 99);
         if (pick < 10)
            c = pattern_cmd(8'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                            8'($urandom));
         else if (pick < 20) begin
            // timeout-only change
            c = last_set;
            c.timeout_hundreds = 8'($urandom);
         end
         else if (pick < 25)
            c = last_set;
         else if (pick < 30)
            c = pattern_cmd(8'd0, 15'($urandom_range(0, 6)), 15'($urandom_range(0, 6)),
                            15'($urandom_range(0, 6)), 8'($urandom_range(0, 2)));
         else
            c = pattern_cmd(8'($urandom_range(1, 4)), 15'($urandom_range(0, 6)),
                            15'($urandom_range(0, 6)), 15'($urandom_range(0, 6)),
                            ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(1, 2)));
         last_set = c;
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 130) : $urandom_range(1, 30);
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            n_holds++;
         end
         else
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // transaction monitors, scoreboard and watchdog
   always @(posedge clock) begin
      logic got;
      got = 1'b0;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = 1'b1;
            rsp_taken++;
            if (rsp_if.payload.sounding)
               n_on++;
            if (levels_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("rsp %0d: unexpected transaction, sounding=%0b", rsp_taken,
                           rsp_if.payload.sounding);
            end
            else begin
               logic lvl;
               lvl = levels_due.pop_front();
               if (rsp_if.payload.sounding !== lvl) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("rsp %0d: sounding expected %0b actual %0b", rsp_taken, lvl,
                              rsp_if.payload.sounding);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            logic lvl;
            got = 1'b1;
            lvl = beeper_step(stim_items[req_taken]);
            case (stim_want[req_taken])
               WANT_OFF: levels_due.push_back(1'b0);
               WANT_ON:  levels_due.push_back(1'b1);
               default:  levels_due.push_back(lvl);
            endcase
            req_taken++;
         end
         idle_cycles = got ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("beep_pattern_sequencer_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      int total;
      int phase;
      bit pressure_done;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      hold_off_req   = 1'b0;
      pressure_done  = 1'b0;
      req_taken = 0; rsp_taken = 0; idle_cycles = 0; mismatches = 0;
      n_sets = 0; n_ticks = 0; n_on = 0; n_timeouts = 0; n_holds = 0;

      mdl_group = '0; mdl_tone = '0; mdl_gap = '0; mdl_rest = '0; mdl_limit = '0;
      mdl_restart = 1'b0; mdl_index = '0; mdl_phase = '0; mdl_elapsed = '0;
      mdl_level = 1'b0;

      dir_rows = '{
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_OFF },
         '{CMD_SET,    8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_OFF },
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_OFF },
         '{CMD_TICK, 8'd255, 15'h7fff, 15'h7fff, 15'h7fff, 8'd255, WANT_OFF },
         '{CMD_SET,    8'd2,     15'd2,     15'd1,     15'd0,   8'd0, WANT_OFF },
         '{CMD_SET,    8'd2,     15'd2,     15'd1,     15'd0,   8'd9, WANT_OFF },
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_OFF },
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_SET,  8'd255, 15'h7fff, 15'h7fff, 15'h7fff, 8'd255, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_OFF },
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_ON  },
         '{CMD_SET,    8'd1,     15'd0,     15'd0,     15'd0,   8'd1, WANT_ON  },
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_OFF },
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_SET,    8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_PRED},
         '{CMD_TICK,   8'd0,     15'd0,     15'd0,     15'd0,   8'd0, WANT_OFF }
      };
      build_stimulus();
      total = stim_items.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < total; i++) begin
         phase = (i < DIR_ROWS) ? 0 : ((i - DIR_ROWS) * 5) / (total - DIR_ROWS);
         case (phase)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 67; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 67; end
            3:       begin send_idle_pct = 38; rsp_stall_pct = 38; end
            default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         endcase
         // receiver goes quiet while the sender keeps offering
         if (phase == 4 && !pressure_done) begin
            hold_off_req  = 1'b1;
            pressure_done = 1'b1;
         end
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
         req_if.valid   <= 1'b1;
         req_if.payload <= stim_items[i];
         do @(posedge clock); while (!req_if.ready);
      end
      req_if.valid <= 1'b0;

      while (levels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d set commands and %0d ticks, %0d results with beeper on",
               n_sets, n_ticks, n_on);
      $display("timeouts reached %0d, long receiver hold-offs %0d, mismatches %0d",
               n_timeouts, n_holds, mismatches);
      if (mismatches == 0)
         $display("beep_pattern_sequencer_top verification clean");
      else
         $display("beep_pattern_sequencer_top verification failed");
      $finish;
   end

endmodule
